// File: hdl/dpbs_pkg.sv
package dpbs_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int PIX_W      = 10;
   localparam int HALF_W     = 12;
   localparam int DEPTH_W    = 16;
   localparam int INV_W      = 24;
   localparam int COORD_W    = 20;
   localparam int MARGIN_W   = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int PROD1_W    = HALF_W + DEPTH_W;
   localparam int PROD2_W    = PROD1_W + INV_W;
   localparam int FRAC_SHIFT = 25;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_COL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_ROW = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FX     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FY     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN     = 3'd4;

   localparam logic [HALF_W-1:0]   RST_CENTER_COL = 12'd639;
   localparam logic [HALF_W-1:0]   RST_CENTER_ROW = 12'd479;
   localparam logic [INV_W-1:0]    RST_INV_FX     = 24'd28926;
   localparam logic [INV_W-1:0]    RST_INV_FY     = 24'd28926;
   localparam logic [MARGIN_W-1:0] RST_MARGIN     = 16'd50;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

endpackage

// File: hdl/depth_pixel_backproject_split.sv
// Depth pixel back-projection with ground split.
// Request channel: one depth pixel per beat (row, column, depth, ground depth
// and their validity flags), accepted when req_valid is high and req_stall low.
// Response channel: one 3-D point per beat, taken when rsp_valid is high and
// rsp_stall low. A pixel with an invalid depth or ground depth, or outside the
// image, gives no response beat.
// Throughput: one pixel per clock while req_stall is low; the datapath is
// four register stages (offset, offset times depth, times reciprocal focal
// length, round and saturate) that each beat passes through in that order.
// Stalls: each stage holds when it is full and the one after it is held, so
// empty slots are squeezed out and req_stall rises only when all stages are
// full and rsp_stall holds the output.
// Reset (synchronous): pipeline emptied, registers back to their defaults.
// CSR writes: csr_write_en with csr_index and csr_write_data, one per cycle,
// to be done only while no pixel is in flight.
module depth_pixel_backproject_split
   import dpbs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [PIX_W-1:0]          req_pixel_row,
   input  logic [PIX_W-1:0]          req_pixel_col,
   input  logic [DEPTH_W-1:0]        req_depth_mm,
   input  logic                      req_depth_valid,
   input  logic [DEPTH_W-1:0]        req_ground_mm,
   input  logic                      req_ground_valid,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_point_x_mm,
   output logic signed [COORD_W-1:0] rsp_point_y_mm,
   output logic [DEPTH_W-1:0]        rsp_point_z_mm,
   output logic                      rsp_is_background,

   input  logic                      csr_write_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data
);

   logic [HALF_W-1:0]   center_col_ff;
   logic [HALF_W-1:0]   center_row_ff;
   logic [INV_W-1:0]    inv_fx_ff;
   logic [INV_W-1:0]    inv_fy_ff;
   logic [MARGIN_W-1:0] margin_ff;

   stage_en_type        en;
   logic                req_accept;
   logic                v1_in;
   logic                v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic [DEPTH_W-1:0]  diff;
   logic                bg1_in;
   logic                bg1_ff, bg2_ff, bg3_ff, bg4_ff;
   logic [DEPTH_W-1:0]  z1_ff, z2_ff, z3_ff, z4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_col_ff <= RST_CENTER_COL;
         center_row_ff <= RST_CENTER_ROW;
         inv_fx_ff     <= RST_INV_FX;
         inv_fy_ff     <= RST_INV_FY;
         margin_ff     <= RST_MARGIN;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CENTER_COL: center_col_ff <= csr_write_data[HALF_W-1:0];
            CSR_CENTER_ROW: center_row_ff <= csr_write_data[HALF_W-1:0];
            CSR_INV_FX:     inv_fx_ff     <= csr_write_data[INV_W-1:0];
            CSR_INV_FY:     inv_fy_ff     <= csr_write_data[INV_W-1:0];
            CSR_MARGIN:     margin_ff     <= csr_write_data[MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   // a stage moves when it is empty or the next one moves
   always_comb begin
      en.s4 = !rsp_valid_ff || !rsp_stall;
      en.s3 = !v3_ff || en.s4;
      en.s2 = !v2_ff || en.s3;
      en.s1 = !v1_ff || en.s2;
   end

   assign req_stall  = !en.s1;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      v1_in = req_accept && req_depth_valid && req_ground_valid
              && (int'(req_pixel_row) < MAX_HEIGHT)
              && (int'(req_pixel_col) < MAX_WIDTH);
      diff   = (req_depth_mm >= req_ground_mm) ? (req_depth_mm - req_ground_mm)
                                               : (req_ground_mm - req_depth_mm);
      bg1_in = diff < margin_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en.s1) v1_ff        <= v1_in;
         if (en.s2) v2_ff        <= v1_ff;
         if (en.s3) v3_ff        <= v2_ff;
         if (en.s4) rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         z1_ff  <= req_depth_mm;
         bg1_ff <= bg1_in;
      end
      if (en.s2) begin
         z2_ff  <= z1_ff;
         bg2_ff <= bg1_ff;
      end
      if (en.s3) begin
         z3_ff  <= z2_ff;
         bg3_ff <= bg2_ff;
      end
      if (en.s4) begin
         z4_ff  <= z3_ff;
         bg4_ff <= bg3_ff;
      end
   end

   dpbs_axis u_axis_x (
      .clock       (clock),
      .en          (en),
      .pix         (req_pixel_col),
      .center_half (center_col_ff),
      .depth       (req_depth_mm),
      .inv_focal   (inv_fx_ff),
      .coord       (rsp_point_x_mm)
   );

   dpbs_axis u_axis_y (
      .clock       (clock),
      .en          (en),
      .pix         (req_pixel_row),
      .center_half (center_row_ff),
      .depth       (req_depth_mm),
      .inv_focal   (inv_fy_ff),
      .coord       (rsp_point_y_mm)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_point_z_mm    = z4_ff;
   assign rsp_is_background = bg4_ff;

`ifndef ASSERT_OFF
   // an empty output stage never holds off a request
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("request stalled with empty output stage");

   // a valid in-image pixel accepted always enters stage one
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_depth_valid && req_ground_valid) |=> v1_ff)
      else $error("accepted pixel lost at stage one");

   // an invalid pixel never produces a stage-one entry
   a_invalid_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (!req_depth_valid || !req_ground_valid)) |=> !v1_ff)
      else $error("invalid pixel entered the pipeline");

   // response taken with nothing behind it leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !v3_ff) |=> !rsp_valid_ff)
      else $error("response beat repeated");
`endif

endmodule

// File: hdl/dpbs_axis.sv
module dpbs_axis
   import dpbs_pkg::*;
(
   input  logic                      clock,
   input  stage_en_type              en,
   input  logic [PIX_W-1:0]          pix,
   input  logic [HALF_W-1:0]         center_half,
   input  logic [DEPTH_W-1:0]        depth,
   input  logic [INV_W-1:0]          inv_focal,
   output logic signed [COORD_W-1:0] coord
);

   localparam int SUM_W = PROD2_W + 1;
   localparam int RND_W = SUM_W - FRAC_SHIFT;
   localparam logic [RND_W-1:0] POS_MAX = RND_W'(2 ** (COORD_W - 1) - 1);
   localparam logic [RND_W-1:0] NEG_MAG = RND_W'(2 ** (COORD_W - 1));
   localparam logic [SUM_W-1:0] HALF_LSB = SUM_W'(2 ** (FRAC_SHIFT - 1));

   logic [HALF_W-1:0]   twice;
   logic [HALF_W-1:0]   mag_in, mag_ff;
   logic                neg1_in, neg1_ff;
   logic [DEPTH_W-1:0]  z1_ff;
   logic [PROD1_W-1:0]  prod1_in, prod1_ff;
   logic                neg2_ff;
   logic [PROD2_W-1:0]  prod2_in, prod2_ff;
   logic                neg3_ff;
   logic [SUM_W-1:0]    sum;
   logic [RND_W-1:0]    rnd;
   logic [RND_W-1:0]    mag_sat;
   logic [COORD_W-1:0]  coord_in, coord_ff;

   // stage 1: offset from centre in half pixels, sign and magnitude
   always_comb begin
      twice   = HALF_W'({pix, 1'b0});
      neg1_in = center_half > twice;
      mag_in  = neg1_in ? (center_half - twice) : (twice - center_half);
   end

   // stage 2: offset times depth
   assign prod1_in = PROD1_W'(mag_ff) * PROD1_W'(z1_ff);

   // stage 3: times reciprocal focal length
   assign prod2_in = PROD2_W'(prod1_ff) * PROD2_W'(inv_focal);

   // stage 4: round half away from zero, saturate
   always_comb begin
      sum = {1'b0, prod2_ff} + HALF_LSB;
      rnd = sum[SUM_W-1:FRAC_SHIFT];
      if (neg3_ff) begin
         mag_sat  = (rnd > NEG_MAG) ? NEG_MAG : rnd;
         coord_in = COORD_W'(0) - mag_sat[COORD_W-1:0];
      end else begin
         mag_sat  = (rnd > POS_MAX) ? POS_MAX : rnd;
         coord_in = mag_sat[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         mag_ff  <= mag_in;
         neg1_ff <= neg1_in;
         z1_ff   <= depth;
      end
      if (en.s2) begin
         prod1_ff <= prod1_in;
         neg2_ff  <= neg1_ff;
      end
      if (en.s3) begin
         prod2_ff <= prod2_in;
         neg3_ff  <= neg2_ff;
      end
      if (en.s4) begin
         coord_ff <= coord_in;
      end
   end

   assign coord = signed'(coord_ff);

endmodule
